>>> design/bpd_pkg.sv
package bpd_pkg;

  localparam int TABLE_ENTRIES = 128;
  localparam int TABLE_AW      = 7;

  localparam logic [7:0] LITERAL_MAX = 8'd127;
  localparam logic [7:0] CODE_BASE   = 8'd128;
  localparam logic [7:0] CODE_END    = 8'd0;

  localparam logic [15:0] LEN_MAX = 16'hFFFF;

  typedef enum logic {
    FUNC_LOAD   = 1'b0,
    FUNC_DECODE = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_POP,
    ST_TABLE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [6:0]  out_byte;
    logic        stored;
    logic        end_of_string;
    logic [15:0] decoded_length;
    logic        overflow;
    logic        last;
  } res_t;

  // core status toward the top level
  typedef struct packed {
    logic res_valid;
    logic in_ready;
  } core_stat_t;

endpackage

>>> design/bpd_core.sv
module bpd_core #(
  parameter int STACK_DEPTH   = 16,
  parameter int MAX_EXPANSION = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic [15:0]       cfg_data,
  input  logic              item_valid,
  input  logic              func,
  input  logic [7:0]        code_byte,
  input  logic [6:0]        entry_index,
  input  logic [7:0]        first_byte,
  input  logic [7:0]        second_byte,
  input  logic              out_free,
  output bpd_pkg::core_stat_t stat,
  output bpd_pkg::res_t     res
);

  localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int NW = $clog2(MAX_EXPANSION + 1);

  bpd_pkg::state_t state_r, state_nxt;

  logic [7:0]    cur_r, cur_nxt;
  logic [SW-1:0] sp_r, sp_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic          cut_r, cut_nxt;
  logic [15:0]   stored_cnt_r, stored_cnt_nxt;
  logic [15:0]   len_cnt_r, len_cnt_nxt;
  logic [15:0]   max_len_r;

  logic          pend_valid_r, pend_valid_nxt;
  logic [6:0]    pend_byte_r, pend_byte_nxt;
  logic          pend_st_r, pend_st_nxt;
  logic [15:0]   pend_len_r, pend_len_nxt;

  // memories
  logic [15:0] tbl_mem [bpd_pkg::TABLE_ENTRIES];
  logic [7:0]  stk_mem [STACK_DEPTH];
  logic [15:0] tbl_rd_r;
  logic [7:0]  stk_rd_r;
  logic        tbl_we, stk_we;
  logic [SW-1:0] stk_raddr;

  // shared conditions
  logic accept, cur_lit, lim_hit, stk_full, lit_now, cut_now, stall;
  logic emit_lit;
  logic lit_st;
  logic [15:0] len_inc;

  assign accept   = item_valid && out_free && (state_r == bpd_pkg::ST_IDLE);
  assign cur_lit  = (cur_r <= bpd_pkg::LITERAL_MAX);
  assign lim_hit  = (n_r >= NW'(MAX_EXPANSION));
  assign stk_full = ((int'(sp_r) + 2) > STACK_DEPTH);
  assign lit_now  = !lim_hit && cur_lit;
  assign cut_now  = lim_hit || (!cur_lit && stk_full);
  assign stall    = lit_now && pend_valid_r && !out_free;
  assign stk_raddr = sp_r - SW'(1);

  assign lit_st  = (({1'b0, stored_cnt_r} + 17'd1) < {1'b0, max_len_r});
  assign len_inc = (len_cnt_r < bpd_pkg::LEN_MAX) ? len_cnt_r + 16'd1 : len_cnt_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bpd_pkg::ST_IDLE: begin
        if (accept && func == bpd_pkg::FUNC_DECODE && code_byte >= bpd_pkg::CODE_BASE) begin
          state_nxt = bpd_pkg::ST_EXPAND;
        end
      end
      bpd_pkg::ST_EXPAND: begin
        if (cut_now) begin
          state_nxt = bpd_pkg::ST_DONE;
        end else if (lit_now) begin
          if (!stall) begin
            state_nxt = (sp_r == '0) ? bpd_pkg::ST_DONE : bpd_pkg::ST_POP;
          end
        end else begin
          state_nxt = bpd_pkg::ST_TABLE;
        end
      end
      bpd_pkg::ST_POP:   state_nxt = bpd_pkg::ST_EXPAND;
      bpd_pkg::ST_TABLE: state_nxt = bpd_pkg::ST_EXPAND;
      bpd_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = bpd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bpd_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    stat           = '0;
    res            = '0;
    cur_nxt        = cur_r;
    sp_nxt         = sp_r;
    n_nxt          = n_r;
    cut_nxt        = cut_r;
    stored_cnt_nxt = stored_cnt_r;
    len_cnt_nxt    = len_cnt_r;
    pend_valid_nxt = pend_valid_r;
    pend_byte_nxt  = pend_byte_r;
    pend_st_nxt    = pend_st_r;
    pend_len_nxt   = pend_len_r;
    tbl_we         = 1'b0;
    stk_we         = 1'b0;
    emit_lit       = 1'b0;
    case (state_r)
      bpd_pkg::ST_IDLE: begin
        stat.in_ready = out_free;
        if (accept) begin
          if (func == bpd_pkg::FUNC_LOAD) begin
            tbl_we = 1'b1;
          end else if (code_byte == bpd_pkg::CODE_END) begin
            stat.res_valid     = 1'b1;
            res.stored         = (max_len_r != 16'd0);
            res.end_of_string  = 1'b1;
            res.decoded_length = len_cnt_r;
            res.last           = 1'b1;
            stored_cnt_nxt     = '0;
            len_cnt_nxt        = 16'd1;
          end else if (code_byte <= bpd_pkg::LITERAL_MAX) begin
            emit_lit           = 1'b1;
            stat.res_valid     = 1'b1;
            res.out_byte       = code_byte[6:0];
            res.stored         = lit_st;
            res.decoded_length = len_inc;
            res.last           = 1'b1;
          end else begin
            cur_nxt        = code_byte;
            sp_nxt         = '0;
            n_nxt          = '0;
            cut_nxt        = 1'b0;
            pend_valid_nxt = 1'b0;
          end
        end
      end
      bpd_pkg::ST_EXPAND: begin
        if (cut_now) begin
          cut_nxt = 1'b1;
        end else if (lit_now) begin
          if (!stall) begin
            // older pending literal is now known not to be last
            if (pend_valid_r) begin
              stat.res_valid     = 1'b1;
              res.out_byte       = pend_byte_r;
              res.stored         = pend_st_r;
              res.decoded_length = pend_len_r;
            end
            emit_lit       = 1'b1;
            pend_valid_nxt = 1'b1;
            pend_byte_nxt  = cur_r[6:0];
            pend_st_nxt    = lit_st;
            pend_len_nxt   = len_inc;
            n_nxt          = n_r + NW'(1);
            if (sp_r != '0) begin
              sp_nxt = sp_r - SW'(1);
            end
          end
        end
      end
      bpd_pkg::ST_POP: begin
        cur_nxt = stk_rd_r;
      end
      bpd_pkg::ST_TABLE: begin
        // second byte goes below, first byte becomes the new top
        stk_we  = 1'b1;
        cur_nxt = tbl_rd_r[15:8];
        sp_nxt  = sp_r + SW'(1);
      end
      bpd_pkg::ST_DONE: begin
        stat.res_valid = out_free;
        res.last       = 1'b1;
        if (pend_valid_r) begin
          res.out_byte       = pend_byte_r;
          res.stored         = pend_st_r;
          res.decoded_length = pend_len_r;
          res.overflow       = cut_r;
        end else begin
          res.decoded_length = len_cnt_r;
          res.overflow       = 1'b1;
        end
        if (out_free) begin
          pend_valid_nxt = 1'b0;
        end
      end
      default: ;
    endcase
    if (emit_lit) begin
      len_cnt_nxt = len_inc;
      if (lit_st && stored_cnt_r < bpd_pkg::LEN_MAX) begin
        stored_cnt_nxt = stored_cnt_r + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[entry_index] <= {first_byte, second_byte};
    end
    tbl_rd_r <= tbl_mem[cur_r[bpd_pkg::TABLE_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[sp_r] <= tbl_rd_r[7:0];
    end
    stk_rd_r <= stk_mem[stk_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bpd_pkg::ST_IDLE;
      sp_r         <= '0;
      n_r          <= '0;
      cut_r        <= 1'b0;
      stored_cnt_r <= '0;
      len_cnt_r    <= 16'd1;
      max_len_r    <= 16'd256;
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sp_r         <= sp_nxt;
      n_r          <= n_nxt;
      cut_r        <= cut_nxt;
      stored_cnt_r <= stored_cnt_nxt;
      len_cnt_r    <= len_cnt_nxt;
      pend_valid_r <= pend_valid_nxt;
      if (cfg_valid) begin
        max_len_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    pend_byte_r <= pend_byte_nxt;
    pend_st_r   <= pend_st_nxt;
    pend_len_r  <= pend_len_nxt;
  end

endmodule

>>> design/byte_pair_decoder.sv
// Byte pair decoder. Load items (tuser 0) write one entry of the 128-entry
// pair table; decode items (tuser 1) take one code byte. A code of 1..127 is
// a literal and gives one item, a zero code gives the terminator item with
// the string's total length and clears the counters, and a code of 128 or
// more is expanded depth-first through the pair table and a STACK_DEPTH-deep
// stack, one literal item per leaf, tlast on the final one. Expansion is cut
// (overflow set on the last item, or a lone marker item if nothing came out)
// when the stack would overrun or after MAX_EXPANSION literals. Load,
// literal and terminator items are handled without leaving the idle
// state. A pair code expands node by node, each node going through a
// registered read of the pair table or stack memory. Output sits in one
// register; the input is held off while that register holds a result
// that is not taken in the same cycle, and an expansion stalls the same
// way. Pair table contents are undefined until loaded; there is no
// clearing pass.
module byte_pair_decoder #(
  parameter int STACK_DEPTH   = 16,
  parameter int MAX_EXPANSION = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // config: max_length
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  // input item
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // code_byte[7:0], entry_index[14:8],
                                  // first_byte[22:15], second_byte[30:23]
  input  logic        in_tuser,   // func
  // result item
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // out_byte[6:0], stored[7], end_of_string[8],
                                  // decoded_length[24:9], overflow[25]
  output logic        out_tlast   // last
);

  bpd_pkg::core_stat_t stat;
  bpd_pkg::res_t       res;
  bpd_pkg::res_t       out_data_r;
  logic                out_valid_r;
  logic                out_free;

  // output register is free when empty or draining this cycle
  assign out_free  = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;
  assign in_tready = stat.in_ready;

  bpd_core #(
    .STACK_DEPTH  (STACK_DEPTH),
    .MAX_EXPANSION(MAX_EXPANSION)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .item_valid (in_tvalid),
    .func       (in_tuser),
    .code_byte  (in_tdata[7:0]),
    .entry_index(in_tdata[14:8]),
    .first_byte (in_tdata[22:15]),
    .second_byte(in_tdata[30:23]),
    .out_free   (out_free),
    .stat       (stat),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stat.res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_data_r.last;
  assign out_tdata  = {6'd0, out_data_r.overflow, out_data_r.decoded_length,
                       out_data_r.end_of_string, out_data_r.stored,
                       out_data_r.out_byte};

  // a new result only lands in a free output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    stat.res_valid |-> out_free)
    else $error("result written over a held output item");

  // a literal or terminator code answers in the cycle it is taken
  a_direct_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser && !in_tdata[7]) |-> stat.res_valid)
    else $error("literal or terminator code gave no result");

  // a pair code holds off the input while it expands
  a_expand_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser && in_tdata[7]) |=> !in_tready)
    else $error("input taken during expansion");

endmodule
